>>> design/path_vertex_chord_smoother_defines.svh
// ----------------------------------------------------------------------------
// Path vertex chord smoother: assertion macros
// Shared property wrappers clocked on clk; one form skips reset, one does not.
// ----------------------------------------------------------------------------
`ifndef PATH_VERTEX_CHORD_SMOOTHER_DEFINES_SVH
`define PATH_VERTEX_CHORD_SMOOTHER_DEFINES_SVH

// check only while out of reset
`define PVCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check at every edge, reset included
`define PVCS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/pvcs_pkg.sv
// ----------------------------------------------------------------------------
// Path vertex chord smoother package
// Field widths, derived datapath widths, payload and control structs.
// ----------------------------------------------------------------------------
package pvcs_pkg;

  localparam int COORD_BITS = 32;
  localparam int ID_BITS    = 16;
  localparam int RATIO_BITS = 16;
  localparam int RATIO_FRAC = 15;

  localparam int MAG_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS = 2 * COORD_BITS + 2;
  localparam int T_BITS    = PROD_BITS + RATIO_BITS;
  localparam int NUM_BITS  = 3 * COORD_BITS + 20;
  localparam int QUO_BITS  = COORD_BITS + 2;
  localparam int CNT_BITS  = $clog2(QUO_BITS + 1);

  typedef struct packed {
    logic signed [ID_BITS-1:0]    point_id;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         final_point;
  } pvcs_in_t;

  typedef struct packed {
    logic signed [ID_BITS-1:0]    out_id;
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic                         path_end;
  } pvcs_out_t;

  typedef struct packed {
    logic go;
    logic div;
  } pvcs_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } pvcs_stat_t;

endpackage

>>> design/path_vertex_chord_smoother.sv
// ----------------------------------------------------------------------------
// Path vertex chord smoother
// Pulls each interior path point toward the chord between its neighbors.
// ----------------------------------------------------------------------------
// Datapath: an interior word with distinct neighbors has its result worked out
//   on the one shared bit-serial multiply/divide unit; other words skip it.
// Flow: one word at a time; the next word is taken only after the last result
//   of the previous word is loaded, through S_FIN and S_IDLE.
// Reset: synchronous, active low; clears the path state and the pull ratio.
module path_vertex_chord_smoother
  import pvcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pvcs_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pvcs_out_t             out_data,
  input  logic                  cfg_wr_en,
  input  logic [RATIO_BITS-1:0] cfg_wr_data
);

`include "path_vertex_chord_smoother_defines.svh"

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_ISSUE = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_EMIT1 = 3'd4;
  localparam logic [2:0] S_EMIT2 = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  localparam logic [3:0] OP_P1 = 4'd0;
  localparam logic [3:0] OP_P2 = 4'd1;
  localparam logic [3:0] OP_SQ = 4'd2;
  localparam logic [3:0] OP_DD = 4'd3;
  localparam logic [3:0] OP_T  = 4'd4;
  localparam logic [3:0] OP_NX = 4'd5;
  localparam logic [3:0] OP_DX = 4'd6;
  localparam logic [3:0] OP_NY = 4'd7;
  localparam logic [3:0] OP_DY = 4'd8;

  localparam logic [1:0] SEEN_NONE = 2'd0;
  localparam logic [1:0] SEEN_ONE  = 2'd1;
  localparam logic [1:0] SEEN_MORE = 2'd2;

  localparam int W = COORD_BITS;

  logic [2:0]            state_r, state_nxt;
  logic [3:0]            op_r;
  logic [RATIO_BITS-1:0] ratio_r;
  pvcs_in_t              cur_r;
  logic [W-1:0]          older_x_r, older_y_r, held_x_r, held_y_r;
  logic [ID_BITS-1:0]    held_id_r;
  logic [1:0]            seen_r;
  logic [MAG_BITS-1:0]   mdx_r, mdy_r, mvx_r, mvy_r;
  logic                  sdx_r, sdy_r, svx_r, svy_r;
  logic [PROD_BITS-1:0]  p1_r, cmag_r, dd_r;
  logic                  cneg_r;
  logic [T_BITS-1:0]     t_r;
  logic [W-1:0]          rx_r;
  pvcs_out_t             r1_r;
  logic                  need2_r;
  logic                  out_valid_r;
  pvcs_out_t             out_data_r;

  // differences against the stored neighbors
  logic [MAG_BITS-1:0] dx, dy, vx, vy;
  logic                dzero;

  assign dx = {cur_r.point_x[W-1], cur_r.point_x} - {older_x_r[W-1], older_x_r};
  assign dy = {cur_r.point_y[W-1], cur_r.point_y} - {older_y_r[W-1], older_y_r};
  assign vx = {held_x_r[W-1], held_x_r} - {older_x_r[W-1], older_x_r};
  assign vy = {held_y_r[W-1], held_y_r} - {older_y_r[W-1], older_y_r};
  assign dzero = (dx == '0) && (dy == '0);

  function automatic logic [MAG_BITS-1:0] mag_of(input logic [MAG_BITS-1:0] v);
    return v[MAG_BITS-1] ? (~v + MAG_BITS'(1)) : v;
  endfunction

  // base +/- min(q, 2^W), clamped to the signed coordinate range
  function automatic logic [W-1:0] pull_sat(input logic [W-1:0]        base,
                                            input logic [QUO_BITS-1:0] q,
                                            input logic                neg);
    logic [MAG_BITS-1:0] qv;
    logic [QUO_BITS-1:0] s;
    if (q[QUO_BITS-1] || (q[W] && (|q[W-1:0]))) qv = {1'b1, {W{1'b0}}};
    else                                          qv = q[MAG_BITS-1:0];
    s = {{2{base[W-1]}}, base};
    s = neg ? (s - {1'b0, qv}) : (s + {1'b0, qv});
    if (s[QUO_BITS-1:W-1] == '0 || s[QUO_BITS-1:W-1] == '1) return s[W-1:0];
    else if (s[QUO_BITS-1]) return {1'b1, {(W-1){1'b0}}};
    else                    return {1'b0, {(W-1){1'b1}}};
  endfunction

  // cross product combine
  logic                 n1, n2, c_ge;
  logic [PROD_BITS-1:0] p2, c_sum, c_d12, c_d21;

  pvcs_cmd_t           md_cmd;
  pvcs_stat_t          md_stat;
  logic [NUM_BITS-1:0] md_opnd, md_pre, md_acc;
  logic [MAG_BITS-1:0] md_mplier;
  logic [QUO_BITS-1:0] md_quot;
  logic [NUM_BITS-1:0] half, den_sh;

  assign p2    = md_acc[PROD_BITS-1:0];
  assign n1    = sdx_r ^ svy_r;
  assign n2    = ~(sdy_r ^ svx_r);
  assign c_sum = p1_r + p2;
  assign c_d12 = p1_r - p2;
  assign c_d21 = p2 - p1_r;
  assign c_ge  = (p1_r >= p2);

  assign half   = NUM_BITS'(dd_r) << (RATIO_FRAC - 1);
  assign den_sh = NUM_BITS'(dd_r) << (RATIO_FRAC + W + 1);

  always_comb begin
    md_cmd.go  = (state_r == S_ISSUE);
    md_cmd.div = 1'b0;
    md_opnd    = '0;
    md_mplier  = '0;
    md_pre     = '0;
    case (op_r)
      OP_P1: begin md_opnd = NUM_BITS'(mdx_r); md_mplier = mvy_r; end
      OP_P2: begin md_opnd = NUM_BITS'(mdy_r); md_mplier = mvx_r; end
      OP_SQ: begin md_opnd = NUM_BITS'(mdx_r); md_mplier = mdx_r; end
      OP_DD: begin
        md_opnd = NUM_BITS'(mdy_r); md_mplier = mdy_r; md_pre = NUM_BITS'(dd_r);
      end
      OP_T: begin
        md_opnd = NUM_BITS'(cmag_r); md_mplier = MAG_BITS'(ratio_r);
      end
      OP_NX: begin md_opnd = NUM_BITS'(t_r); md_mplier = mdy_r; md_pre = half; end
      OP_NY: begin md_opnd = NUM_BITS'(t_r); md_mplier = mdx_r; md_pre = half; end
      OP_DX, OP_DY: begin md_cmd.div = 1'b1; md_opnd = den_sh; end
      default: ;
    endcase
  end

  pvcs_muldiv u_muldiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (md_cmd),
    .opnd    (md_opnd),
    .mplier  (md_mplier),
    .preload (md_pre),
    .stat    (md_stat),
    .acc     (md_acc),
    .quot    (md_quot)
  );

  logic out_free, out_load;
  pvcs_out_t out_word;

  assign out_free = !out_valid_r || out_ready;
  assign out_load = out_free && (state_r == S_EMIT1 || state_r == S_EMIT2);
  assign out_word = (state_r == S_EMIT1) ? r1_r :
                    pvcs_out_t'{out_id: cur_r.point_id, out_x: cur_r.point_x,
                                out_y: cur_r.point_y, path_end: 1'b1};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_SETUP;
      S_SETUP: begin
        if (seen_r == SEEN_MORE && !dzero) state_nxt = S_ISSUE;
        else if (seen_r != SEEN_ONE || cur_r.final_point) state_nxt = S_EMIT1;
        else state_nxt = S_FIN;
      end
      S_ISSUE: state_nxt = S_WAIT;
      S_WAIT: begin
        if (md_stat.done) state_nxt = (op_r == OP_DY) ? S_EMIT1 : S_ISSUE;
      end
      S_EMIT1: if (out_free) state_nxt = need2_r ? S_EMIT2 : S_FIN;
      S_EMIT2: if (out_free) state_nxt = S_FIN;
      S_FIN:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_P1;
      ratio_r     <= '0;
      seen_r      <= SEEN_NONE;
      older_x_r   <= '0;
      older_y_r   <= '0;
      held_id_r   <= '0;
      held_x_r    <= '0;
      held_y_r    <= '0;
      need2_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) ratio_r <= cfg_wr_data;

      if (out_load)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: if (in_valid) cur_r <= in_data;
        S_SETUP: begin
          op_r  <= OP_P1;
          mdx_r <= mag_of(dx); sdx_r <= dx[MAG_BITS-1];
          mdy_r <= mag_of(dy); sdy_r <= dy[MAG_BITS-1];
          mvx_r <= mag_of(vx); svx_r <= vx[MAG_BITS-1];
          mvy_r <= mag_of(vy); svy_r <= vy[MAG_BITS-1];
          case (seen_r)
            SEEN_NONE: begin
              need2_r <= cur_r.final_point;
              r1_r    <= '{out_id: cur_r.point_id, out_x: cur_r.point_x,
                           out_y: cur_r.point_y, path_end: 1'b0};
            end
            SEEN_ONE: begin
              need2_r <= 1'b0;
              r1_r    <= '{out_id: cur_r.point_id, out_x: cur_r.point_x,
                           out_y: cur_r.point_y, path_end: 1'b1};
            end
            default: begin
              need2_r <= cur_r.final_point;
              r1_r    <= '{out_id: held_id_r, out_x: held_x_r,
                           out_y: held_y_r, path_end: 1'b0};
            end
          endcase
        end
        S_WAIT: if (md_stat.done) begin
          op_r <= op_r + 4'd1;
          case (op_r)
            OP_P1: p1_r <= md_acc[PROD_BITS-1:0];
            OP_P2: begin
              if (n1 == n2) begin
                cmag_r <= c_sum; cneg_r <= n1;
              end else if (c_ge) begin
                cmag_r <= c_d12; cneg_r <= n1;
              end else begin
                cmag_r <= c_d21; cneg_r <= n2;
              end
            end
            OP_SQ, OP_DD: dd_r <= md_acc[PROD_BITS-1:0];
            OP_T:  t_r  <= md_acc[T_BITS-1:0];
            OP_DX: rx_r <= pull_sat(held_x_r, md_quot, sdy_r ^ cneg_r);
            OP_DY: r1_r <= '{out_id: ID_BITS'(1), out_x: rx_r,
                             out_y: pull_sat(held_y_r, md_quot, ~(sdx_r ^ cneg_r)),
                             path_end: 1'b0};
            default: ;
          endcase
        end
        S_FIN: begin
          if (cur_r.final_point) begin
            seen_r <= SEEN_NONE;
          end else begin
            // advance the window: held becomes older, new point is held
            if (seen_r != SEEN_NONE) begin
              older_x_r <= held_x_r;
              older_y_r <= held_y_r;
            end
            held_id_r <= cur_r.point_id;
            held_x_r  <= cur_r.point_x;
            held_y_r  <= cur_r.point_y;
            seen_r    <= (seen_r == SEEN_NONE) ? SEEN_ONE : SEEN_MORE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data_r <= out_word;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PVCS_ASSERT(a_accept_to_setup, (in_valid && in_ready) |=> (state_r == S_SETUP),
               "accepted word did not enter setup")
  `PVCS_ASSERT(a_seen_range, (seen_r == SEEN_NONE || seen_r == SEEN_ONE || seen_r == SEEN_MORE),
               "point count out of range")
  `PVCS_ASSERT(a_issue_idle_unit, md_cmd.go |-> !md_stat.busy,
               "arithmetic unit started while busy")
  `PVCS_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> (!out_valid_r && state_r == S_IDLE),
                      "reset did not clear control state")

endmodule

>>> design/pvcs_muldiv.sv
// ----------------------------------------------------------------------------
// Bit-serial multiply / divide unit
// Shift-add multiply (one multiplier bit per cycle, with accumulator preload)
// and restoring divide of the accumulator (one quotient bit per cycle).
// ----------------------------------------------------------------------------
module pvcs_muldiv
  import pvcs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  pvcs_cmd_t           cmd,
  input  logic [NUM_BITS-1:0] opnd,
  input  logic [MAG_BITS-1:0] mplier,
  input  logic [NUM_BITS-1:0] preload,
  output pvcs_stat_t          stat,
  output logic [NUM_BITS-1:0] acc,
  output logic [QUO_BITS-1:0] quot
);

  logic [NUM_BITS-1:0] acc_r, opnd_r;
  logic [MAG_BITS-1:0] b_r;
  logic [QUO_BITS-1:0] q_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic                busy_r, div_r, done_r;

  logic [NUM_BITS-1:0] sum, diff;
  logic                ge;

  assign sum  = acc_r + opnd_r;
  assign diff = acc_r - opnd_r;
  assign ge   = (acc_r >= opnd_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      div_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.go) begin
        busy_r <= 1'b1;
        div_r  <= cmd.div;
        opnd_r <= opnd;
        if (cmd.div) begin
          q_r   <= '0;
          cnt_r <= CNT_BITS'(QUO_BITS);
        end else begin
          acc_r <= preload;
          b_r   <= mplier;
          cnt_r <= CNT_BITS'(MAG_BITS);
        end
      end else if (busy_r) begin
        if (div_r) begin
          // compare against the shifted divisor, take one quotient bit
          if (ge) acc_r <= diff;
          q_r    <= {q_r[QUO_BITS-2:0], ge};
          opnd_r <= opnd_r >> 1;
        end else begin
          if (b_r[0]) acc_r <= sum;
          opnd_r <= opnd_r << 1;
          b_r    <= b_r >> 1;
        end
        cnt_r <= cnt_r - CNT_BITS'(1);
        if (cnt_r == CNT_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign acc       = acc_r;
  assign quot      = q_r;

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// Path vertex chord smoother testbench
// Sends paths of points through the block under random idling and stalls.
// An internal predictor computes the expected smoothed points, and a
// scoreboard compares every output word field by field, oldest first.
// ----------------------------------------------------------------------------
module tb_top
  import pvcs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  DRAIN_CYCLES = 400;
  localparam longint CYCLE_LIMIT = 3_000_000;
  localparam logic signed [63:0] CMAX = 64'sd2147483647;
  localparam logic signed [63:0] CMIN = -64'sd2147483648;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  pvcs_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  pvcs_out_t out_data;
  logic      cfg_wr_en = 1'b0;
  logic [RATIO_BITS-1:0] cfg_wr_data = '0;

  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  longint cycles = 0;

  always #4 clk = ~clk;

  path_vertex_chord_smoother i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  class smoother_scoreboard;
    pvcs_out_t             smoothed_q[$];
    int                    errors;
    logic [RATIO_BITS-1:0] ratio;
    logic signed [63:0]    older_x, older_y, held_x, held_y;
    logic [ID_BITS-1:0]    held_id;
    int                    seen;

    function void clear();
      ratio = '0;
      older_x = 0; older_y = 0; held_x = 0; held_y = 0;
      held_id = '0; seen = 0; errors = 0;
    endfunction

    function void push(logic [ID_BITS-1:0] id, logic signed [63:0] x,
                       logic signed [63:0] y, logic last);
      pvcs_out_t w;
      w.out_id = id; w.out_x = x[31:0]; w.out_y = y[31:0]; w.path_end = last;
      smoothed_q = {smoothed_q, w};
    endfunction

    // base +/- round(ratio * dmag * cmag / (dd * 2^15)), move capped, then clamp
    function logic signed [63:0] pull(logic signed [63:0] base, logic [79:0] dmag,
                                      logic [79:0] cmag, bit neg, logic [79:0] dd);
      logic [191:0]       num, den, q;
      logic [63:0]        qv;
      logic signed [63:0] r;
      num = 192'(ratio) * 192'(dmag) * 192'(cmag) + (192'(dd) << (RATIO_FRAC - 1));
      den = 192'(dd) << RATIO_FRAC;
      q = num / den;
      qv = (q > 192'(64'h1_0000_0000)) ? 64'h1_0000_0000 : q[63:0];
      r = neg ? base - $signed(qv) : base + $signed(qv);
      if (r > CMAX) r = CMAX;
      if (r < CMIN) r = CMIN;
      return r;
    endfunction

    function void note_input(pvcs_in_t w);
      logic signed [63:0] x, y;
      logic signed [79:0] dx, dy, vx, vy, c;
      logic [79:0]        cmag, dd, adx, ady;
      bit                 cneg;
      x = w.point_x; y = w.point_y;
      if (seen == 0) begin
        push(w.point_id, x, y, 1'b0);
        if (w.final_point) begin
          push(w.point_id, x, y, 1'b1);
          return;
        end
        held_id = w.point_id; held_x = x; held_y = y; seen = 1;
        return;
      end
      if (seen == 1) begin
        if (w.final_point) begin
          push(w.point_id, x, y, 1'b1);
          seen = 0;
          return;
        end
      end else begin
        dx = x - older_x; dy = y - older_y;
        vx = held_x - older_x; vy = held_y - older_y;
        if (dx == 0 && dy == 0) begin
          push(held_id, held_x, held_y, 1'b0);
        end else begin
          c = dx * vy - dy * vx;
          cneg = c < 0;
          cmag = cneg ? -c : c;
          adx = dx < 0 ? -dx : dx;
          ady = dy < 0 ? -dy : dy;
          dd = adx * adx + ady * ady;
          push(16'd1,
               pull(held_x, ady, cmag, (dy < 0) != cneg, dd),
               pull(held_y, adx, cmag, !((dx < 0) != cneg), dd), 1'b0);
        end
        if (w.final_point) begin
          push(w.point_id, x, y, 1'b1);
          seen = 0;
          return;
        end
      end
      older_x = held_x; older_y = held_y;
      held_id = w.point_id; held_x = x; held_y = y; seen = 2;
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h, expected %h", what, got, want);
      errors++;
    endtask

    task check(pvcs_out_t w);
      pvcs_out_t e;
      if (smoothed_q.size() == 0) begin
        report("unexpected word", 64'(w), 64'h0);
        return;
      end
      e = smoothed_q.pop_front();
      if (w.out_id !== e.out_id) report("out_id", 64'(w.out_id), 64'(e.out_id));
      if (w.out_x !== e.out_x) report("out_x", 64'(w.out_x), 64'(e.out_x));
      if (w.out_y !== e.out_y) report("out_y", 64'(w.out_y), 64'(e.out_y));
      if (w.path_end !== e.path_end) report("path_end", 64'(w.path_end), 64'(e.path_end));
    endtask
  endclass

  smoother_scoreboard sb = new();

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check(out_data);
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // hold valid until taken, then maybe drop it for a random gap
  task send(logic [15:0] id, logic [31:0] x, logic [31:0] y, logic last);
    pvcs_in_t w;
    w.point_id = id; w.point_x = x; w.point_y = y; w.final_point = last;
    in_data <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task set_ratio(logic [RATIO_BITS-1:0] v);
    in_valid <= 1'b0;
    while (sb.smoothed_q.size() != 0) @(posedge clk);
    @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.ratio = v;
  endtask

  function logic [31:0] rand_coord();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 4) return $urandom;
    if (pick < 8) return 32'($signed($urandom_range(8191)) - 4096) << $urandom_range(16);
    return pick == 8 ? 32'h7fff_ffff : 32'h8000_0000;
  endfunction

  task random_path(output int len);
    logic [31:0] px[$], py[$];
    logic [31:0] x, y;
    len = ($urandom_range(9) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      x = rand_coord(); y = rand_coord();
      // reuse the point two back to make coinciding neighbors
      if (i >= 2 && $urandom_range(7) == 0) begin
        x = px[i-2]; y = py[i-2];
      end
      px = {px, x}; py = {py, y};
      send(16'($urandom), x, y, i == len - 1);
    end
  endtask

  initial begin
    int sent;
    int plen;
    sb.clear();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero ratio first (reset value), then write it explicitly
    send(16'h7fff, 32'h7fff_ffff, 32'h8000_0000, 1'b1);          // one-point path
    send(16'h8000, 32'h8000_0000, 32'h7fff_ffff, 1'b0);          // two-point path
    send(16'hffff, 32'h0001_0000, 32'hffff_0000, 1'b1);
    send(16'h0005, 32'h0, 32'h0, 1'b0);                           // zero ratio interior
    send(16'h0006, 32'h0003_0000, 32'h0002_0000, 1'b0);
    send(16'h0007, 32'h0006_0000, 32'h0, 1'b1);
    set_ratio(16'h0000);
    set_ratio(16'hffff);
    send(16'h0010, 32'h0005_0000, 32'h0005_0000, 1'b0);          // coinciding neighbors
    send(16'h0011, 32'h0009_0000, 32'h0001_0000, 1'b0);
    send(16'h0012, 32'h0005_0000, 32'h0005_0000, 1'b1);
    send(16'h0020, 32'h8000_0000, 32'h0, 1'b0);                   // clamp low in x
    send(16'h0021, 32'h7fff_ffff, 32'h0, 1'b0);
    send(16'h0022, 32'h8000_0000, 32'h0000_0001, 1'b0);
    send(16'h0023, 32'h0, 32'h7fff_ffff, 1'b0);                   // clamp high in y
    send(16'h0024, 32'h0000_0001, 32'h8000_0000, 1'b1);
    send(16'h0030, 32'h0, 32'h0, 1'b0);                           // plain bend
    send(16'h0031, 32'h0002_0000, 32'h0003_0000, 1'b0);
    send(16'h0032, 32'h0004_0000, 32'h0, 1'b0);
    send(16'h0033, 32'hfffe_0000, 32'hffff_8000, 1'b1);
    set_ratio(16'h8000);
    send(16'h0040, 32'h0, 32'h0, 1'b0);
    send(16'h0041, 32'h0001_0000, 32'h0001_0001, 1'b0);
    send(16'h0042, 32'h0002_0000, 32'h0, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin set_ratio(16'hffff); send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin set_ratio(16'h8000); send_idle_pct = 69; recv_stall_pct = 0; end
        2: begin set_ratio(16'($urandom)); send_idle_pct = 0; recv_stall_pct = 69; end
        default: begin set_ratio(16'h0001); send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      sent = 0;
      while (sent < 320) begin
        random_path(plen);
        sent = sent + plen;
      end
    end

    in_valid <= 1'b0;
    while (sb.smoothed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

>>> path_vertex_chord_smoother.f
+incdir+design
design/pvcs_pkg.sv
design/pvcs_muldiv.sv
design/path_vertex_chord_smoother.sv
sim/tb_top.sv
